/* hw/rtl/lam_pkg.sv */
// Shared types, constants and modular helpers for the lazy affine array.
package lam_pkg;

   localparam int VAL_W     = 24;
   localparam int OP_W      = 3;
   localparam int IDX_W     = 10;
   localparam int CNT_W     = 11;
   localparam int EPOCH_W   = 8;
   localparam int RED_W     = 25;
   localparam int LIM_W     = 27;
   localparam int STEP_W    = 4;
   localparam int BIT_W     = 5;
   localparam int IDX_STEPS = IDX_W;

   localparam logic [VAL_W-1:0] PRIME     = 24'd10000019;
   localparam logic [VAL_W-1:0] INV_EXP   = PRIME - 24'd2;
   localparam logic [RED_W-1:0] BARRETT_M = 25'((64'd1 << 48) / 64'd10000019);
   localparam logic [CNT_W-1:0] COUNT_RST = 11'd1024;

   // Opcodes
   localparam logic [OP_W-1:0] OP_ASSIGN = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL    = 3'd2;
   localparam logic [OP_W-1:0] OP_SET    = 3'd3;
   localparam logic [OP_W-1:0] OP_QELEM  = 3'd4;
   localparam logic [OP_W-1:0] OP_QTOT   = 3'd5;

   typedef logic [3:0] src_type;
   typedef logic [2:0] dst_type;
   typedef logic [3:0] alu_type;

   // Multiplier operand sources
   localparam src_type SRC_NONE  = 4'd0;
   localparam src_type SRC_V     = 4'd1;
   localparam src_type SRC_MULT  = 4'd2;
   localparam src_type SRC_ADD   = 4'd3;
   localparam src_type SRC_TOTAL = 4'd4;
   localparam src_type SRC_ACC   = 4'd5;
   localparam src_type SRC_BASE  = 4'd6;
   localparam src_type SRC_TMP   = 4'd7;
   localparam src_type SRC_RD    = 4'd8;
   localparam src_type SRC_COUNT = 4'd9;

   // Multiplier result destinations
   localparam dst_type DST_NONE  = 3'd0;
   localparam dst_type DST_MULT  = 3'd1;
   localparam dst_type DST_ADD   = 3'd2;
   localparam dst_type DST_TOTAL = 3'd3;
   localparam dst_type DST_ACC   = 3'd4;
   localparam dst_type DST_BASE  = 3'd5;

   // Small modular operations
   localparam alu_type ALU_NONE       = 4'd0;
   localparam alu_type ALU_OLD        = 4'd1;
   localparam alu_type ALU_TOT_SUB    = 4'd2;
   localparam alu_type ALU_TOT_ADDV   = 4'd3;
   localparam alu_type ALU_DIFF       = 4'd4;
   localparam alu_type ALU_INV_INIT   = 4'd5;
   localparam alu_type ALU_TOT_ADDMUL = 4'd6;
   localparam alu_type ALU_ADD_V      = 4'd7;
   localparam alu_type ALU_OUT        = 4'd8;
   localparam alu_type ALU_OUT_TOT    = 4'd9;
   localparam alu_type ALU_SETALL     = 4'd10;

   typedef struct packed {
      logic              latch;
      logic              idx_step;
      logic [STEP_W-1:0] idx_shift;
      logic              mem_rd;
      logic              mem_wr;
      logic              clr;
      logic              epoch_inc;
      logic              epoch_one;
      logic              mul_go;
      src_type           mul_a;
      src_type           mul_b;
      dst_type           dst;
      alu_type           alu;
   } cmd_type;

   typedef struct packed {
      logic            mul_done;
      logic            v_zero;
      logic            epoch_full;
      logic            clr_last;
      logic [OP_W-1:0] op;
   } status_type;

   function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, PRIME}) begin
         s = s - {1'b0, PRIME};
      end
      return s[VAL_W-1:0];
   endfunction

   function automatic logic [VAL_W-1:0] mod_sub(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      s = {1'b0, a} + {1'b0, PRIME} - {1'b0, b};
      if (s >= {1'b0, PRIME}) begin
         s = s - {1'b0, PRIME};
      end
      return s[VAL_W-1:0];
   endfunction

endpackage

/* hw/rtl/lam_modmul.sv */
// Five-stage Barrett modular multiplier for the fixed prime.
module lam_modmul (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  logic [lam_pkg::VAL_W-1:0] a,
   input  logic [lam_pkg::VAL_W-1:0] b,
   output logic                      done,
   output logic [lam_pkg::VAL_W-1:0] res
);

   logic [4:0]  stage_ff;
   logic [47:0] prod1_ff;
   logic [48:0] t2_ff;
   logic [lam_pkg::RED_W-1:0] p2_ff;
   logic [47:0] qp3_ff;
   logic [lam_pkg::RED_W-1:0] p3_ff;
   logic [lam_pkg::RED_W-1:0] r4_ff;
   logic [lam_pkg::VAL_W-1:0] res_ff;
   logic [lam_pkg::VAL_W-1:0] res_in;

   localparam logic [lam_pkg::RED_W-1:0] P1 = {1'b0, lam_pkg::PRIME};
   localparam logic [lam_pkg::RED_W-1:0] P2 = {lam_pkg::PRIME, 1'b0};

   // Final correction: remainder estimate is below three times the prime
   always_comb begin
      if (r4_ff >= P2) begin
         res_in = lam_pkg::VAL_W'(r4_ff - P2);
      end else if (r4_ff >= P1) begin
         res_in = lam_pkg::VAL_W'(r4_ff - P1);
      end else begin
         res_in = r4_ff[lam_pkg::VAL_W-1:0];
      end
   end

   // Track the item through the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= {stage_ff[3:0], go};
      end
   end

   // Product, quotient estimate, quotient times prime, remainder, correction
   always_ff @(posedge clock) begin
      prod1_ff <= 48'(a) * 48'(b);
      t2_ff    <= 49'(prod1_ff[46:23]) * 49'(lam_pkg::BARRETT_M);
      p2_ff    <= prod1_ff[lam_pkg::RED_W-1:0];
      qp3_ff   <= 48'(t2_ff[48:25]) * 48'(lam_pkg::PRIME);
      p3_ff    <= p2_ff;
      r4_ff    <= p3_ff - qp3_ff[lam_pkg::RED_W-1:0];
      if (stage_ff[3]) begin
         res_ff <= res_in;
      end
   end

   assign done = stage_ff[4];
   assign res  = res_ff;

endmodule

/* hw/rtl/lam_datapath.sv */
// Datapath: tags, total, entry memory, multiplier and small modular operations.
module lam_datapath #(
   parameter int DEPTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lam_pkg::cmd_type            cmd,
   output lam_pkg::status_type         status,
   input  logic [lam_pkg::OP_W-1:0]    req_opcode,
   input  logic [lam_pkg::IDX_W-1:0]   req_element_index,
   input  logic [lam_pkg::VAL_W-1:0]   req_operand_value,
   input  logic                        csr_valid,
   input  logic [lam_pkg::CNT_W-1:0]   csr_element_count,
   output logic                        rsp_valid,
   output logic [lam_pkg::VAL_W-1:0]   rsp_query_result
);

   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int VW    = lam_pkg::VAL_W;
   localparam int WORDW = lam_pkg::EPOCH_W + VW;

   logic [lam_pkg::OP_W-1:0]    op_ff, op_in;
   logic [lam_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [VW-1:0]               v_ff, v_in;
   logic [VW-1:0]               mult_ff, mult_in;
   logic [VW-1:0]               add_ff, add_in;
   logic [VW-1:0]               total_ff, total_in;
   logic [VW-1:0]               acc_ff, acc_in;
   logic [VW-1:0]               base_ff, base_in;
   logic [VW-1:0]               tmp_ff, tmp_in;
   logic [VW-1:0]               res_ff, res_in;
   logic                        strobe_ff, strobe_in;
   logic [lam_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [lam_pkg::EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [IW-1:0]               clr_addr_ff, clr_addr_in;
   logic [WORDW-1:0]            rd_ff;
   logic [WORDW-1:0]            mem [DEPTH];

   logic [IW-1:0]                addr;
   logic [VW-1:0]                stored;
   logic [lam_pkg::LIM_W-1:0]    lim;
   logic                         clr_last;
   logic [VW-1:0]                mul_a, mul_b, mul_res;
   logic                         mul_done;

   assign addr     = IW'(idx_ff);
   assign clr_last = (clr_addr_ff == IW'(DEPTH - 1));
   assign lim      = lam_pkg::LIM_W'(DEPTH) << cmd.idx_shift;

   // Entries written under an older epoch read as zero
   assign stored = (rd_ff[WORDW-1:VW] == epoch_ff) ? rd_ff[VW-1:0] : '0;

   // Select multiplier operands
   always_comb begin
      case (cmd.mul_a)
         lam_pkg::SRC_V:     mul_a = v_ff;
         lam_pkg::SRC_MULT:  mul_a = mult_ff;
         lam_pkg::SRC_ADD:   mul_a = add_ff;
         lam_pkg::SRC_TOTAL: mul_a = total_ff;
         lam_pkg::SRC_ACC:   mul_a = acc_ff;
         lam_pkg::SRC_BASE:  mul_a = base_ff;
         lam_pkg::SRC_TMP:   mul_a = tmp_ff;
         lam_pkg::SRC_RD:    mul_a = stored;
         lam_pkg::SRC_COUNT: mul_a = VW'(count_ff);
         default:            mul_a = '0;
      endcase
      case (cmd.mul_b)
         lam_pkg::SRC_V:     mul_b = v_ff;
         lam_pkg::SRC_MULT:  mul_b = mult_ff;
         lam_pkg::SRC_ADD:   mul_b = add_ff;
         lam_pkg::SRC_TOTAL: mul_b = total_ff;
         lam_pkg::SRC_ACC:   mul_b = acc_ff;
         lam_pkg::SRC_BASE:  mul_b = base_ff;
         lam_pkg::SRC_TMP:   mul_b = tmp_ff;
         lam_pkg::SRC_RD:    mul_b = stored;
         lam_pkg::SRC_COUNT: mul_b = VW'(count_ff);
         default:            mul_b = '0;
      endcase
   end

   lam_modmul u_modmul (
      .clock (clock),
      .reset (reset),
      .go    (cmd.mul_go),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .res   (mul_res)
   );

   // Next-state logic for the datapath registers
   always_comb begin
      op_in       = op_ff;
      idx_in      = idx_ff;
      v_in        = v_ff;
      mult_in     = mult_ff;
      add_in      = add_ff;
      total_in    = total_ff;
      acc_in      = acc_ff;
      base_in     = base_ff;
      tmp_in      = tmp_ff;
      res_in      = res_ff;
      strobe_in   = 1'b0;
      count_in    = count_ff;
      epoch_in    = epoch_ff;
      clr_addr_in = clr_addr_ff;

      // Capture a new item, reducing the operand below the prime
      if (cmd.latch) begin
         op_in  = req_opcode;
         idx_in = req_element_index;
         if (req_operand_value >= lam_pkg::PRIME) begin
            v_in = req_operand_value - lam_pkg::PRIME;
         end else begin
            v_in = req_operand_value;
         end
      end

      // One restoring step of index modulo depth
      if (cmd.idx_step) begin
         if (lam_pkg::LIM_W'(idx_ff) >= lim) begin
            idx_in = idx_ff - lim[lam_pkg::IDX_W-1:0];
         end
      end

      // Route a finished product
      case (cmd.dst)
         lam_pkg::DST_MULT:  mult_in  = mul_res;
         lam_pkg::DST_ADD:   add_in   = mul_res;
         lam_pkg::DST_TOTAL: total_in = mul_res;
         lam_pkg::DST_ACC:   acc_in   = mul_res;
         lam_pkg::DST_BASE:  base_in  = mul_res;
         default:            ;
      endcase

      case (cmd.alu)
         lam_pkg::ALU_OLD:        tmp_in   = lam_pkg::mod_add(mul_res, add_ff);
         lam_pkg::ALU_TOT_SUB:    total_in = lam_pkg::mod_sub(total_ff, tmp_ff);
         lam_pkg::ALU_TOT_ADDV:   total_in = lam_pkg::mod_add(total_ff, v_ff);
         lam_pkg::ALU_DIFF:       tmp_in   = lam_pkg::mod_sub(v_ff, add_ff);
         lam_pkg::ALU_INV_INIT: begin
            acc_in  = VW'(1);
            base_in = mult_ff;
         end
         lam_pkg::ALU_TOT_ADDMUL: total_in = lam_pkg::mod_add(total_ff, mul_res);
         lam_pkg::ALU_ADD_V:      add_in   = lam_pkg::mod_add(add_ff, v_ff);
         lam_pkg::ALU_OUT: begin
            res_in    = lam_pkg::mod_add(mul_res, add_ff);
            strobe_in = 1'b1;
         end
         lam_pkg::ALU_OUT_TOT: begin
            res_in    = total_ff;
            strobe_in = 1'b1;
         end
         lam_pkg::ALU_SETALL: begin
            mult_in = VW'(1);
            add_in  = v_ff;
         end
         default: ;
      endcase

      if (cmd.epoch_inc) begin
         epoch_in = epoch_ff + 1'b1;
      end
      if (cmd.epoch_one) begin
         epoch_in = lam_pkg::EPOCH_W'(1);
      end

      if (cmd.clr) begin
         clr_addr_in = clr_last ? '0 : clr_addr_ff + 1'b1;
      end

      if (csr_valid) begin
         count_in = csr_element_count;
      end
   end

   // Architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff     <= VW'(1);
         add_ff      <= '0;
         total_ff    <= '0;
         count_ff    <= lam_pkg::COUNT_RST;
         epoch_ff    <= lam_pkg::EPOCH_W'(1);
         clr_addr_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         mult_ff     <= mult_in;
         add_ff      <= add_in;
         total_ff    <= total_in;
         count_ff    <= count_in;
         epoch_ff    <= epoch_in;
         clr_addr_ff <= clr_addr_in;
         strobe_ff   <= strobe_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      idx_ff  <= idx_in;
      v_ff    <= v_in;
      acc_ff  <= acc_in;
      base_ff <= base_in;
      tmp_ff  <= tmp_in;
      res_ff  <= res_in;
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.mem_wr) begin
         mem[addr] <= {epoch_ff, mul_res};
      end
      if (cmd.mem_rd) begin
         rd_ff <= mem[addr];
      end
   end

   assign status.mul_done   = mul_done;
   assign status.v_zero     = (v_ff == '0);
   assign status.epoch_full = &epoch_ff;
   assign status.clr_last   = clr_last;
   assign status.op         = op_ff;

   assign rsp_valid        = strobe_ff;
   assign rsp_query_result = res_ff;

endmodule

/* hw/rtl/lam_ctrl.sv */
// Controller: sequences each operation as commands to the datapath.
module lam_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lam_pkg::status_type status,
   output lam_pkg::cmd_type    cmd
);

   localparam logic [4:0] S_CLEAR    = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_DISP     = 5'd2;
   localparam logic [4:0] S_IDX      = 5'd3;
   localparam logic [4:0] S_READ     = 5'd4;
   localparam logic [4:0] S_OLD_GO   = 5'd5;
   localparam logic [4:0] S_OLD_WAIT = 5'd6;
   localparam logic [4:0] S_TOT_SUB  = 5'd7;
   localparam logic [4:0] S_TOT_ADD  = 5'd8;
   localparam logic [4:0] S_DIFF     = 5'd9;
   localparam logic [4:0] S_INV_INIT = 5'd10;
   localparam logic [4:0] S_EXP      = 5'd11;
   localparam logic [4:0] S_EXP_MW   = 5'd12;
   localparam logic [4:0] S_EXP_SQ   = 5'd13;
   localparam logic [4:0] S_EXP_SW   = 5'd14;
   localparam logic [4:0] S_FIN_GO   = 5'd15;
   localparam logic [4:0] S_FIN_WAIT = 5'd16;
   localparam logic [4:0] S_ADD_GO   = 5'd17;
   localparam logic [4:0] S_ADD_WAIT = 5'd18;
   localparam logic [4:0] S_ADD_TAG  = 5'd19;
   localparam logic [4:0] S_MUL1_GO  = 5'd20;
   localparam logic [4:0] S_MUL1_W   = 5'd21;
   localparam logic [4:0] S_MUL2_GO  = 5'd22;
   localparam logic [4:0] S_MUL2_W   = 5'd23;
   localparam logic [4:0] S_MUL3_GO  = 5'd24;
   localparam logic [4:0] S_MUL3_W   = 5'd25;
   localparam logic [4:0] S_SET      = 5'd26;
   localparam logic [4:0] S_SCLR     = 5'd27;
   localparam logic [4:0] S_SET_GO   = 5'd28;
   localparam logic [4:0] S_SET_W    = 5'd29;
   localparam logic [4:0] S_OUT_TOT  = 5'd30;

   logic [4:0]                  state_ff, state_in;
   logic [lam_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [lam_pkg::BIT_W-1:0]   bit_ff, bit_in;

   // Issue a product on the shared multiplier
   function automatic lam_pkg::cmd_type mul_cmd(input lam_pkg::cmd_type c,
                                                input lam_pkg::src_type a,
                                                input lam_pkg::src_type b);
      lam_pkg::cmd_type r;
      r        = c;
      r.mul_go = 1'b1;
      r.mul_a  = a;
      r.mul_b  = b;
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      bit_in   = bit_ff;
      cmd      = '0;
      cmd.idx_shift = step_ff;

      case (state_ff)
         // Sweep the memory back to the never-written state
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (status.clr_last) begin
               cmd.epoch_one = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            step_in = lam_pkg::STEP_W'(lam_pkg::IDX_STEPS - 1);
            case (status.op)
               lam_pkg::OP_ASSIGN: state_in = S_IDX;
               lam_pkg::OP_QELEM:  state_in = S_IDX;
               lam_pkg::OP_ADD:    state_in = S_ADD_GO;
               lam_pkg::OP_MUL:    state_in = status.v_zero ? S_SET : S_MUL1_GO;
               lam_pkg::OP_SET:    state_in = S_SET;
               lam_pkg::OP_QTOT:   state_in = S_OUT_TOT;
               default:            state_in = S_IDLE;
            endcase
         end
         // Reduce the index one bit position a cycle
         S_IDX: begin
            cmd.idx_step = 1'b1;
            if (step_ff == '0) begin
               state_in = S_READ;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_OLD_GO;
         end
         // Present value of the entry: stored times multiplier tag, plus addend tag
         S_OLD_GO: begin
            cmd      = mul_cmd(cmd, lam_pkg::SRC_RD, lam_pkg::SRC_MULT);
            state_in = S_OLD_WAIT;
         end
         S_OLD_WAIT: begin
            if (status.mul_done) begin
               if (status.op == lam_pkg::OP_QELEM) begin
                  cmd.alu  = lam_pkg::ALU_OUT;
                  state_in = S_IDLE;
               end else begin
                  cmd.alu  = lam_pkg::ALU_OLD;
                  state_in = S_TOT_SUB;
               end
            end
         end
         S_TOT_SUB: begin
            cmd.alu  = lam_pkg::ALU_TOT_SUB;
            state_in = S_TOT_ADD;
         end
         S_TOT_ADD: begin
            cmd.alu  = lam_pkg::ALU_TOT_ADDV;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.alu  = lam_pkg::ALU_DIFF;
            state_in = S_INV_INIT;
         end
         S_INV_INIT: begin
            cmd.alu  = lam_pkg::ALU_INV_INIT;
            bit_in   = '0;
            state_in = S_EXP;
         end
         // Square-and-multiply over the exponent bits, low bit first
         S_EXP: begin
            if (lam_pkg::INV_EXP[bit_ff]) begin
               cmd      = mul_cmd(cmd, lam_pkg::SRC_ACC, lam_pkg::SRC_BASE);
               state_in = S_EXP_MW;
            end else begin
               state_in = S_EXP_SQ;
            end
         end
         S_EXP_MW: begin
            if (status.mul_done) begin
               cmd.dst  = lam_pkg::DST_ACC;
               state_in = S_EXP_SQ;
            end
         end
         S_EXP_SQ: begin
            if (bit_ff == lam_pkg::BIT_W'(lam_pkg::VAL_W - 1)) begin
               state_in = S_FIN_GO;
            end else begin
               cmd      = mul_cmd(cmd, lam_pkg::SRC_BASE, lam_pkg::SRC_BASE);
               state_in = S_EXP_SW;
            end
         end
         S_EXP_SW: begin
            if (status.mul_done) begin
               cmd.dst  = lam_pkg::DST_BASE;
               bit_in   = bit_ff + 1'b1;
               state_in = S_EXP;
            end
         end
         // Store the difference times the inverse
         S_FIN_GO: begin
            cmd      = mul_cmd(cmd, lam_pkg::SRC_TMP, lam_pkg::SRC_ACC);
            state_in = S_FIN_WAIT;
         end
         S_FIN_WAIT: begin
            if (status.mul_done) begin
               cmd.mem_wr = 1'b1;
               state_in   = S_IDLE;
            end
         end
         // Add to all
         S_ADD_GO: begin
            cmd      = mul_cmd(cmd, lam_pkg::SRC_V, lam_pkg::SRC_COUNT);
            state_in = S_ADD_WAIT;
         end
         S_ADD_WAIT: begin
            if (status.mul_done) begin
               cmd.alu  = lam_pkg::ALU_TOT_ADDMUL;
               state_in = S_ADD_TAG;
            end
         end
         S_ADD_TAG: begin
            cmd.alu  = lam_pkg::ALU_ADD_V;
            state_in = S_IDLE;
         end
         // Multiply all: scale both tags and the total
         S_MUL1_GO: begin
            cmd      = mul_cmd(cmd, lam_pkg::SRC_MULT, lam_pkg::SRC_V);
            state_in = S_MUL1_W;
         end
         S_MUL1_W: begin
            if (status.mul_done) begin
               cmd.dst  = lam_pkg::DST_MULT;
               state_in = S_MUL2_GO;
            end
         end
         S_MUL2_GO: begin
            cmd      = mul_cmd(cmd, lam_pkg::SRC_ADD, lam_pkg::SRC_V);
            state_in = S_MUL2_W;
         end
         S_MUL2_W: begin
            if (status.mul_done) begin
               cmd.dst  = lam_pkg::DST_ADD;
               state_in = S_MUL3_GO;
            end
         end
         S_MUL3_GO: begin
            cmd      = mul_cmd(cmd, lam_pkg::SRC_TOTAL, lam_pkg::SRC_V);
            state_in = S_MUL3_W;
         end
         S_MUL3_W: begin
            if (status.mul_done) begin
               cmd.dst  = lam_pkg::DST_TOTAL;
               state_in = S_IDLE;
            end
         end
         // Set all: new epoch, or a full sweep when the epoch runs out
         S_SET: begin
            cmd.alu = lam_pkg::ALU_SETALL;
            if (status.epoch_full) begin
               state_in = S_SCLR;
            end else begin
               cmd.epoch_inc = 1'b1;
               state_in      = S_SET_GO;
            end
         end
         S_SCLR: begin
            cmd.clr = 1'b1;
            if (status.clr_last) begin
               cmd.epoch_one = 1'b1;
               state_in      = S_SET_GO;
            end
         end
         S_SET_GO: begin
            cmd      = mul_cmd(cmd, lam_pkg::SRC_V, lam_pkg::SRC_COUNT);
            state_in = S_SET_W;
         end
         S_SET_W: begin
            if (status.mul_done) begin
               cmd.dst  = lam_pkg::DST_TOTAL;
               state_in = S_IDLE;
            end
         end
         S_OUT_TOT: begin
            cmd.alu  = lam_pkg::ALU_OUT_TOT;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         step_ff  <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         bit_ff   <= bit_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* hw/rtl/lazy_affine_array_modular.sv */
// Top level of the lazy affine modular array: controller plus datapath.
//
// Array of DEPTH residues modulo 10000019 under a global multiplier and addend
// tag, with a running total. Raise start with an item while busy is low; the
// block then holds busy high until the item is done. Query results appear on
// rsp_query_result for exactly one cycle with rsp_valid high and cannot be
// stalled. All multiplications go through one five-stage Barrett multiplier
// used one product at a time, so the run time of an operation follows the
// number of products it needs: an assign takes ten index reduction steps,
// one product for the old value, a 24-bit square-and-multiply inverse with
// 33 products and one product to store; a query of an element takes the
// index steps and one product, add and set one product, multiply all three,
// query total none. After reset the block sweeps the entry memory before it
// drops busy and takes items; every 255th set-all (or multiply by zero) adds
// another sweep. The element count register can be written at any time
// csr_ready is high.
module lazy_affine_array_modular #(
   parameter int DEPTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [lam_pkg::OP_W-1:0]    req_opcode,
   input  logic [lam_pkg::IDX_W-1:0]   req_element_index,
   input  logic [lam_pkg::VAL_W-1:0]   req_operand_value,
   output logic                        rsp_valid,
   output logic [lam_pkg::VAL_W-1:0]   rsp_query_result,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lam_pkg::CNT_W-1:0]   csr_element_count
);

   lam_pkg::cmd_type    cmd;
   lam_pkg::status_type status;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   lam_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   lam_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_element_index (req_element_index),
      .req_operand_value (req_operand_value),
      .csr_valid         (csr_valid & csr_ready),
      .csr_element_count (csr_element_count),
      .rsp_valid         (rsp_valid),
      .rsp_query_result  (rsp_query_result)
   );

endmodule
